// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lfu_pkg.sv =====
`default_nettype none

package lfu_pkg;

  localparam int KEY_W = 32;
  localparam int DATA_W = 32;
  localparam int CFG_W = 5;
  localparam int DEF_ENTRIES = 16;
  localparam int DEF_COUNT_BITS = 16;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_EVICT
  } lfu_state_t;

  typedef struct packed {
    logic load_in;
    logic finish_look;
    logic scan_start;
    logic scan_step;
    logic finish_evict;
  } lfu_cmd_t;

  typedef struct packed {
    logic need_evict;
    logic scan_last;
    logic out_busy;
  } lfu_sts_t;

endpackage

`default_nettype wire

// ===== rtl/lfu_ctrl.sv =====
`default_nettype none

module lfu_ctrl
  import lfu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lfu_sts_t sts,
  output lfu_cmd_t      cmd
);

  lfu_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_LOOK;
      end
      S_LOOK: begin
        if (sts.need_evict) state_next = S_SCAN;
        else if (!sts.out_busy) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (sts.scan_last) state_next = S_EVICT;
      end
      S_EVICT: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        cmd.load_in = in_valid && !rst;
      end
      S_LOOK: begin
        cmd.scan_start = sts.need_evict;
        cmd.finish_look = !sts.need_evict && !sts.out_busy;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_EVICT: begin
        cmd.finish_evict = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lfu_dp.sv =====
`default_nettype none

module lfu_dp
  import lfu_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wen,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_mode,
  input  wire logic [KEY_W-1:0]  in_key,
  input  wire logic [DATA_W-1:0] in_value,
  input  wire lfu_cmd_t          cmd,
  output lfu_sts_t               sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_hit,
  output logic [DATA_W-1:0]      out_read_value,
  output logic                   out_evicted,
  output logic [KEY_W-1:0]       out_evicted_key
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [ENTRIES-1:0]    valid;
  logic [KEY_W-1:0]      key_mem  [ENTRIES];
  logic [DATA_W-1:0]     data_mem [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem  [ENTRIES];
  logic [IDX_W-1:0]      rank_mem [ENTRIES];
  logic [OCC_W-1:0]      occupancy;
  logic [CFG_W-1:0]      capacity;

  logic                  req_put;
  logic [KEY_W-1:0]      req_key;
  logic [DATA_W-1:0]     req_val;

  logic [IDX_W-1:0]      scan_idx;
  logic                  best_found;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [IDX_W-1:0]      best_rank;
  logic [IDX_W-1:0]      best_idx;
  logic [KEY_W-1:0]      best_key;

  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    free_vec;
  logic [ENTRIES-1:0]    free_low;
  logic                  hit;
  logic [IDX_W-1:0]      hit_rank;
  logic [DATA_W-1:0]     hit_data;
  logic [CMP_W-1:0]      cap_eff;
  logic                  cap_nz;
  logic                  do_touch;
  logic                  do_insert;
  logic                  better;
  logic                  load_out;

  always_comb begin
    hit_rank = '0;
    hit_data = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid[i] && (key_mem[i] == req_key);
      if (match[i]) begin
        hit_rank = hit_rank | rank_mem[i];
        hit_data = hit_data | data_mem[i];
      end
    end
  end

  assign hit = |match;
  assign free_vec = ~valid;
  assign free_low = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});

  assign cap_eff = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(capacity);
  assign cap_nz = (cap_eff != '0);

  assign sts.need_evict = req_put && !hit && cap_nz && (CMP_W'(occupancy) >= cap_eff);
  assign sts.scan_last = (scan_idx == IDX_W'(ENTRIES - 1));
  assign sts.out_busy = out_valid && !out_ready;

  assign do_touch = cmd.finish_look && hit && (!req_put || cap_nz);
  assign do_insert = cmd.finish_look && req_put && !hit && cap_nz;
  assign load_out = cmd.finish_look || cmd.finish_evict;

  assign better = valid[scan_idx] &&
                  (!best_found || (cnt_mem[scan_idx] < best_cnt) ||
                   ((cnt_mem[scan_idx] == best_cnt) && (rank_mem[scan_idx] > best_rank)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occupancy <= '0;
      capacity <= CAP_RESET;
      out_valid <= 1'b0;
      best_found <= 1'b0;
    end else begin
      if (cfg_wen) capacity <= cfg_wdata;
      if (do_insert) begin
        valid <= valid | free_low;
        occupancy <= occupancy + OCC_W'(1);
      end
      if (cmd.scan_start) begin
        best_found <= 1'b0;
      end else if (cmd.scan_step && better) begin
        best_found <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_put <= in_mode;
      req_key <= in_key;
      req_val <= in_value;
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_step && !sts.scan_last) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (cmd.scan_step && better) begin
      best_cnt <= cnt_mem[scan_idx];
      best_rank <= rank_mem[scan_idx];
      best_idx <= scan_idx;
      best_key <= key_mem[scan_idx];
    end
    if (cmd.finish_look) begin
      out_hit <= hit;
      out_read_value <= req_put ? '0 : (hit ? hit_data : '1);
      out_evicted <= 1'b0;
      out_evicted_key <= '0;
    end else if (cmd.finish_evict) begin
      out_hit <= 1'b0;
      out_read_value <= '0;
      out_evicted <= 1'b1;
      out_evicted_key <= best_key;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_touch) begin
        if (match[i]) begin
          if (cnt_mem[i] != CNT_MAX) cnt_mem[i] <= cnt_mem[i] + COUNT_BITS'(1);
          rank_mem[i] <= '0;
          if (req_put) data_mem[i] <= req_val;
        end else if (valid[i] && (rank_mem[i] < hit_rank)) begin
          rank_mem[i] <= rank_mem[i] + IDX_W'(1);
        end
      end
      if (do_insert) begin
        if (free_low[i]) begin
          key_mem[i] <= req_key;
          data_mem[i] <= req_val;
          cnt_mem[i] <= COUNT_BITS'(1);
          rank_mem[i] <= '0;
        end else if (valid[i]) begin
          rank_mem[i] <= rank_mem[i] + IDX_W'(1);
        end
      end
      if (cmd.finish_evict) begin
        if (best_idx == IDX_W'(i)) begin
          key_mem[i] <= req_key;
          data_mem[i] <= req_val;
          cnt_mem[i] <= COUNT_BITS'(1);
          rank_mem[i] <= '0;
        end else if (valid[i] && (rank_mem[i] < best_rank)) begin
          rank_mem[i] <= rank_mem[i] + IDX_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfu_cache_table.sv =====
// Gets, updates and inserts that need no eviction: the word is registered in IDLE, and
// LOOK loads the result once the output is free; no new word is taken until then.
// A put of a new key into a full table scans one entry per cycle for the victim,
// then EVICT replaces it once the output is free.
// Synchronous active-high reset empties the table and sets capacity to 16.
`default_nettype none

module lfu_cache_table
  import lfu_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wen,
  input  wire logic [CFG_W-1:0]          cfg_wdata,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [KEY_W+DATA_W-1:0]   s_axis_tdata,  // key, value
  input  wire logic [0:0]                s_axis_tuser,  // mode
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [DATA_W+KEY_W-1:0]        m_axis_tdata,  // read_value, evicted_key
  output logic [1:0]                     m_axis_tuser   // hit, evicted
);

  lfu_cmd_t          cmd;
  lfu_sts_t          sts;
  logic              out_hit;
  logic              out_evicted;
  logic [DATA_W-1:0] out_read_value;
  logic [KEY_W-1:0]  out_evicted_key;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfu_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (s_axis_tuser[0]),
    .in_key          (s_axis_tdata[KEY_W-1:0]),
    .in_value        (s_axis_tdata[KEY_W+DATA_W-1:KEY_W]),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

  assign m_axis_tdata = {out_evicted_key, out_read_value};
  assign m_axis_tuser = {out_evicted, out_hit};

endmodule

`default_nettype wire

// ===== rtl/lfu_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module lfu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result word dropped while stalled")
  `ASSERT_IMPLY(a_evict_no_hit, clk, rst, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0], "eviction reported with a hit")
  `ASSERT_IMPLY(a_evict_rdata, clk, rst, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[31:0] == 32'd0, "eviction with nonzero read value")
  `ASSERT_IMPLY(a_no_evict_key, clk, rst, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[63:32] == 32'd0, "victim key without eviction")
  `ASSERT_IMPLY(a_reset_idle, clk, rst, $past(rst), !m_axis_tvalid, "result word right after reset")

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/lfu_cache_table_test.sv =====
`default_nettype none

module lfu_cache_table_test;
  import lfu_pkg::*;

  localparam int ENTRIES = DEF_ENTRIES;
  localparam int COUNT_MAX = (1 << DEF_COUNT_BITS) - 1;
  localparam bit MODE_GET = 1'b0;
  localparam bit MODE_PUT = 1'b1;
  localparam int HOT_GETS = 20;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } cache_result_t;

  class lfu_scoreboard;
    bit            valid [ENTRIES];
    logic [31:0]   keys [ENTRIES];
    logic [31:0]   data [ENTRIES];
    int            uses [ENTRIES];
    int            rank [ENTRIES];
    int            occupancy;
    int            capacity;
    int            errors;
    cache_result_t expected_q [$];

    function new();
      foreach (valid[i]) valid[i] = 1'b0;
      occupancy = 0;
      capacity = 16;
      errors = 0;
    endfunction

    function void set_capacity(logic [CFG_W-1:0] c);
      capacity = c;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [31:0] any_key();
      int i;
      i = $urandom_range(ENTRIES - 1);
      while (!valid[i]) i = $urandom_range(ENTRIES - 1);
      return keys[i];
    endfunction

    function void bump(int e);
      int old_rank;
      if (uses[e] < COUNT_MAX) uses[e]++;
      old_rank = rank[e];
      for (int i = 0; i < ENTRIES; i++)
        if (valid[i] && i != e && rank[i] < old_rank) rank[i]++;
      rank[e] = 0;
    endfunction

    function void note_word(bit mode, logic [31:0] k, logic [31:0] v);
      int slot, victim, free_slot, lim, victim_rank;
      cache_result_t r;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && valid[i] && keys[i] == k) slot = i;
      r.hit = (slot >= 0);
      r.read_value = '0;
      r.evicted = 1'b0;
      r.evicted_key = '0;
      lim = (capacity > ENTRIES) ? ENTRIES : capacity;
      if (mode == MODE_GET) begin
        if (slot >= 0) begin
          bump(slot);
          r.read_value = data[slot];
        end else begin
          r.read_value = '1;
        end
      end else if (lim != 0) begin
        if (slot >= 0) begin
          data[slot] = v;
          bump(slot);
        end else begin
          if (occupancy >= lim) begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++)
              if (valid[i] && (victim < 0 || uses[i] < uses[victim] ||
                  (uses[i] == uses[victim] && rank[i] > rank[victim])))
                victim = i;
            if (victim >= 0) begin
              victim_rank = rank[victim];
              r.evicted = 1'b1;
              r.evicted_key = keys[victim];
              valid[victim] = 1'b0;
              for (int i = 0; i < ENTRIES; i++)
                if (valid[i] && rank[i] > victim_rank) rank[i]--;
              occupancy--;
            end
          end
          free_slot = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (free_slot < 0 && !valid[i]) free_slot = i;
          if (free_slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
              if (valid[i]) rank[i]++;
            valid[free_slot] = 1'b1;
            keys[free_slot] = k;
            data[free_slot] = v;
            uses[free_slot] = 1;
            rank[free_slot] = 0;
            occupancy++;
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_word(cache_result_t got);
      cache_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word expected none actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
      compare_field("evicted_key", want.evicted_key, got.evicted_key);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wen;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata;
  logic [0:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [63:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;

  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  lfu_scoreboard sb = new();

  lfu_cache_table u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_word('{hit: m_axis_tuser[0], read_value: m_axis_tdata[31:0],
                      evicted: m_axis_tuser[1], evicted_key: m_axis_tdata[63:32]});
    end
  end

  // The receiver stalls at random, and holds off for a long stretch on request.
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_en && $urandom_range(99) < 37);
      end
    end
  end

  initial begin
    #16_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_word(bit mode, logic [31:0] k, logic [31:0] v);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {v, k};
    s_axis_tuser <= mode;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(mode, k, v);
    if (idle_en && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] c);
    wait_drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.set_capacity(c);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] c, int n_words, bit quiet, bit hold,
                           bit pause_mid);
    logic [31:0] pool [$];
    logic [31:0] k;
    int sel;
    write_capacity(c);
    idle_en = !quiet;
    pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    repeat (c % 17 + 4) pool.push_back($urandom());
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < n_words; i++) begin
      if (pause_mid && i == n_words / 2) wait_drain();
      sel = $urandom_range(99);
      if (sel < 45 && sb.occupancy != 0) k = sb.any_key();
      else if (sel < 85) k = pool[$urandom_range(pool.size() - 1)];
      else k = $urandom();
      send_word(($urandom_range(99) < 55) ? MODE_PUT : MODE_GET, k, $urandom());
    end
    idle_en = 1'b1;
  endtask

  initial begin
    logic [31:0] key_a, key_b;
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= MODE_GET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_capacity(5'd16);
    send_word(MODE_GET, 32'h0000_0000, 32'h0000_0000);
    send_word(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_word(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_word(MODE_PUT, 32'h0000_0000, 32'h0000_0000);
    send_word(MODE_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_word(MODE_GET, 32'h8000_0000, 32'h5555_5555);
    send_word(MODE_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_word(MODE_GET, 32'hffff_ffff, 32'h0000_0000);
    send_word(MODE_PUT, 32'h0000_0000, 32'h1234_5678);
    send_word(MODE_GET, 32'h0000_0000, 32'h0000_0000);
    send_word(MODE_GET, 32'h5555_5555, 32'h0000_0000);
    write_capacity(5'd2);
    send_word(MODE_PUT, 32'haaaa_aaaa, 32'h0000_0001);
    send_word(MODE_PUT, 32'h5555_5555, 32'h0000_0002);
    send_word(MODE_GET, 32'haaaa_aaaa, 32'h0000_0000);
    write_capacity(5'd0);
    send_word(MODE_PUT, 32'h0bad_cafe, 32'h0000_0003);
    send_word(MODE_PUT, 32'h5555_5555, 32'h0000_0004);
    send_word(MODE_GET, 32'h5555_5555, 32'h0000_0000);
    send_word(MODE_GET, 32'h0bad_cafe, 32'h0000_0000);
    write_capacity(5'd31);
    send_word(MODE_PUT, 32'h0000_0001, 32'hdead_beef);
    send_word(MODE_PUT, 32'hfedc_ba98, 32'h0000_0000);

    // Make one entry heavily used, then make it compete for eviction
    // against a lightly used entry.
    write_capacity(5'd16);
    idle_en = 1'b0;
    key_a = $urandom();
    key_b = ~key_a;
    send_word(MODE_PUT, key_a, $urandom());
    repeat (HOT_GETS) send_word(MODE_GET, key_a, 32'h0000_0000);
    send_word(MODE_PUT, key_b, $urandom());
    repeat (9) send_word(MODE_GET, key_b, 32'h0000_0000);
    send_word(MODE_GET, key_a, 32'h0000_0000);
    write_capacity(5'd2);
    idle_en = 1'b0;
    send_word(MODE_PUT, key_a ^ 32'h0000_ffff, $urandom());
    send_word(MODE_PUT, key_b ^ 32'hffff_0000, $urandom());
    send_word(MODE_GET, key_a, 32'h0000_0000);
    idle_en = 1'b1;

    run_phase(5'd1, 80, 1'b0, 1'b0, 1'b0);
    run_phase(5'd16, 100, 1'b0, 1'b0, 1'b1);
    run_phase(5'd0, 60, 1'b0, 1'b0, 1'b0);
    run_phase(5'd5, 90, 1'b0, 1'b1, 1'b0);
    run_phase(5'd31, 100, 1'b0, 1'b0, 1'b0);
    run_phase(5'd3, 90, 1'b1, 1'b0, 1'b0);
    run_phase(5'd16, 110, 1'b0, 1'b0, 1'b0);
    run_phase(5'd8, 90, 1'b0, 1'b0, 1'b1);
    run_phase(5'd2, 80, 1'b0, 1'b0, 1'b0);
    run_phase(5'd0, 40, 1'b0, 1'b0, 1'b0);
    run_phase(5'd12, 100, 1'b0, 1'b0, 1'b0);
    run_phase(5'd16, 80, 1'b0, 1'b0, 1'b0);
    wait_drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_ctrl.sv
rtl/lfu_dp.sv
rtl/lfu_cache_table.sv
rtl/lfu_checker.sv
tb/lfu_cache_table_test.sv
